// ----- rtl/olist_pkg.sv -----
// olist_pkg: shared types, constants and codes for the ordered list engine
package olist_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CMD_W       = 4;
    localparam int POS_W       = 5;
    localparam int STATUS_W    = 3;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_TAIL   = 4'd0,
        CMD_INS_HEAD   = 4'd1,
        CMD_INS_POS    = 4'd2,
        CMD_FIND       = 4'd3,
        CMD_FIND_ALL   = 4'd4,
        CMD_DEL_HEAD   = 4'd5,
        CMD_DEL_TAIL   = 4'd6,
        CMD_INS_AFTER  = 4'd7,
        CMD_INS_BEFORE = 4'd8,
        CMD_DEL_POS    = 4'd9,
        CMD_DEL_VALUE  = 4'd10,
        CMD_READ       = 4'd11
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] position;
        t_value           value;
        t_value           key;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    found_position;
        logic [CNT_W-1:0]    match_count;
        logic [DEPTH-1:0]    match_mask;
        t_value              read_value;
        logic [CNT_W-1:0]    list_length;
    } t_out_word;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_op;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] ptr;
        t_value           data;
    } t_cell_ctrl;

endpackage

// ----- rtl/olist_cell.sv -----
// olist_cell: one list slot, shifts with its neighbors and compares against the key
module olist_cell (
    input  logic                          i_clk,
    input  logic [olist_pkg::IDX_W-1:0]   i_idx,
    input  olist_pkg::t_cell_ctrl         i_ctrl,
    input  olist_pkg::t_value             i_key,
    input  olist_pkg::t_value             i_left,
    input  olist_pkg::t_value             i_right,
    output olist_pkg::t_value             o_entry,
    output logic                          o_match
);

    olist_pkg::t_value r_entry;
    olist_pkg::t_value n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.op)
            olist_pkg::CELL_HOLD: begin
                n_entry = r_entry;
            end
            olist_pkg::CELL_INS: begin
                // cells past the insert point take the lower neighbor
                if (i_idx > i_ctrl.ptr) begin
                    n_entry = i_left;
                end else if (i_idx == i_ctrl.ptr) begin
                    n_entry = i_ctrl.data;
                end
            end
            olist_pkg::CELL_DEL: begin
                if (i_idx >= i_ctrl.ptr) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_key);

endmodule

// ----- rtl/olist_ctrl.sv -----
// olist_ctrl: decodes one command against the match vector and picks the cell operation
module olist_ctrl (
    input  olist_pkg::t_in_word           i_cmd_word,
    input  logic [olist_pkg::CNT_W-1:0]   i_count,
    input  logic [olist_pkg::DEPTH-1:0]   i_match,
    input  olist_pkg::t_value             i_entries [olist_pkg::DEPTH],
    output olist_pkg::t_cell_ctrl         o_cell_ctrl,
    output olist_pkg::t_out_word          o_result
);

    localparam int CMP_W = ((olist_pkg::POS_W > olist_pkg::CNT_W) ?
                            olist_pkg::POS_W : olist_pkg::CNT_W) + 1;
    localparam int NIB_N = (olist_pkg::DEPTH + 3) / 4;

    logic                        any_match;
    logic [olist_pkg::IDX_W-1:0] first_idx;
    logic [olist_pkg::CNT_W-1:0] found_pos;
    logic [olist_pkg::CNT_W-1:0] pop_count;
    logic [2:0]                  nib_count [NIB_N];
    logic                        empty;
    logic                        full;
    logic [CMP_W-1:0]            pos_w;
    logic [CMP_W-1:0]            count_w;
    logic                        ins_range_ok;
    logic                        del_range_ok;
    logic [olist_pkg::IDX_W-1:0] pos_idx;
    logic [olist_pkg::IDX_W-1:0] last_idx;
    logic [olist_pkg::CNT_W-1:0] count_next;

    // priority encode of the first match
    always_comb begin
        first_idx = '0;
        for (int i = olist_pkg::DEPTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                first_idx = olist_pkg::IDX_W'(i);
            end
        end
    end

    assign any_match = |i_match;
    assign found_pos = any_match ?
                       (olist_pkg::CNT_W'(first_idx) + olist_pkg::CNT_W'(1)) : '0;

    // match count as nibble sums then a short final add
    always_comb begin
        pop_count = '0;
        for (int n = 0; n < NIB_N; n++) begin
            nib_count[n] = '0;
            for (int b = 0; b < 4; b++) begin
                if (n * 4 + b < olist_pkg::DEPTH) begin
                    nib_count[n] = nib_count[n] + 3'(i_match[n * 4 + b]);
                end
            end
        end
        for (int n = 0; n < NIB_N; n++) begin
            pop_count = pop_count + olist_pkg::CNT_W'(nib_count[n]);
        end
    end

    assign empty        = (i_count == '0);
    assign full         = (i_count == olist_pkg::CNT_W'(olist_pkg::DEPTH));
    assign pos_w        = CMP_W'(i_cmd_word.position);
    assign count_w      = CMP_W'(i_count);
    assign ins_range_ok = (pos_w != '0) && (pos_w <= count_w + CMP_W'(1));
    assign del_range_ok = (pos_w != '0) && (pos_w <= count_w);
    assign pos_idx      = olist_pkg::IDX_W'(i_cmd_word.position - olist_pkg::POS_W'(1));
    assign last_idx     = olist_pkg::IDX_W'(i_count - olist_pkg::CNT_W'(1));

    always_comb begin
        o_cell_ctrl.op   = olist_pkg::CELL_HOLD;
        o_cell_ctrl.ptr  = '0;
        o_cell_ctrl.data = i_cmd_word.value;
        o_result         = '0;
        o_result.status  = olist_pkg::ST_OK;
        count_next       = i_count;

        unique case (olist_pkg::t_cmd'(i_cmd_word.cmd))
            olist_pkg::CMD_INS_TAIL, olist_pkg::CMD_INS_HEAD: begin
                if (full) begin
                    o_result.status = olist_pkg::ST_FULL;
                end else begin
                    o_cell_ctrl.op  = olist_pkg::CELL_INS;
                    o_cell_ctrl.ptr = (olist_pkg::t_cmd'(i_cmd_word.cmd) ==
                                       olist_pkg::CMD_INS_TAIL) ?
                                      olist_pkg::IDX_W'(i_count) : '0;
                    count_next      = i_count + olist_pkg::CNT_W'(1);
                end
            end
            olist_pkg::CMD_INS_POS: begin
                if (full) begin
                    o_result.status = olist_pkg::ST_FULL;
                end else if (!ins_range_ok) begin
                    o_result.status = olist_pkg::ST_RANGE;
                end else begin
                    o_cell_ctrl.op  = olist_pkg::CELL_INS;
                    o_cell_ctrl.ptr = pos_idx;
                    count_next      = i_count + olist_pkg::CNT_W'(1);
                end
            end
            olist_pkg::CMD_FIND: begin
                if (empty) begin
                    o_result.status = olist_pkg::ST_EMPTY;
                end else begin
                    o_result.found_position = found_pos;
                    if (!any_match) begin
                        o_result.status = olist_pkg::ST_NOT_FOUND;
                    end
                end
            end
            olist_pkg::CMD_FIND_ALL: begin
                if (empty) begin
                    o_result.status = olist_pkg::ST_EMPTY;
                end else begin
                    o_result.found_position = found_pos;
                    o_result.match_count    = pop_count;
                    o_result.match_mask     = i_match;
                    if (!any_match) begin
                        o_result.status = olist_pkg::ST_NOT_FOUND;
                    end
                end
            end
            olist_pkg::CMD_DEL_HEAD, olist_pkg::CMD_DEL_TAIL: begin
                if (empty) begin
                    o_result.status = olist_pkg::ST_EMPTY;
                end else begin
                    o_cell_ctrl.op  = olist_pkg::CELL_DEL;
                    o_cell_ctrl.ptr = (olist_pkg::t_cmd'(i_cmd_word.cmd) ==
                                       olist_pkg::CMD_DEL_HEAD) ? '0 : last_idx;
                    count_next      = i_count - olist_pkg::CNT_W'(1);
                end
            end
            olist_pkg::CMD_INS_AFTER, olist_pkg::CMD_INS_BEFORE: begin
                if (empty) begin
                    o_result.status = olist_pkg::ST_EMPTY;
                end else if (full) begin
                    o_result.status = olist_pkg::ST_FULL;
                end else if (!any_match) begin
                    o_result.status = olist_pkg::ST_NOT_FOUND;
                end else begin
                    o_result.found_position = found_pos;
                    o_cell_ctrl.op  = olist_pkg::CELL_INS;
                    // before: new word takes the key's slot and pushes the key up
                    o_cell_ctrl.ptr = (olist_pkg::t_cmd'(i_cmd_word.cmd) ==
                                       olist_pkg::CMD_INS_AFTER) ?
                                      (first_idx + olist_pkg::IDX_W'(1)) : first_idx;
                    count_next      = i_count + olist_pkg::CNT_W'(1);
                end
            end
            olist_pkg::CMD_DEL_POS, olist_pkg::CMD_READ: begin
                if (empty) begin
                    o_result.status = olist_pkg::ST_EMPTY;
                end else if (!del_range_ok) begin
                    o_result.status = olist_pkg::ST_RANGE;
                end else if (olist_pkg::t_cmd'(i_cmd_word.cmd) ==
                             olist_pkg::CMD_DEL_POS) begin
                    o_cell_ctrl.op  = olist_pkg::CELL_DEL;
                    o_cell_ctrl.ptr = pos_idx;
                    count_next      = i_count - olist_pkg::CNT_W'(1);
                end else begin
                    o_result.read_value = i_entries[pos_idx];
                end
            end
            olist_pkg::CMD_DEL_VALUE: begin
                if (empty) begin
                    o_result.status = olist_pkg::ST_EMPTY;
                end else if (!any_match) begin
                    o_result.status = olist_pkg::ST_NOT_FOUND;
                end else begin
                    o_result.found_position = found_pos;
                    o_cell_ctrl.op  = olist_pkg::CELL_DEL;
                    o_cell_ctrl.ptr = first_idx;
                    count_next      = i_count - olist_pkg::CNT_W'(1);
                end
            end
            default: begin
                o_result.status = olist_pkg::ST_OK;
            end
        endcase

        o_result.list_length = count_next;
    end

endmodule

// ----- rtl/ordered_list_engine.sv -----
// ordered_list_engine: top level, chain of list cells with command sequencer and output register
//
// Ordered list of up to 16 signed 32-bit words held in a chain of cells, position 1 in
// cell 0. A command word passes through the states S_IDLE, S_SRCH and S_UPD. In S_IDLE,
// the word is accepted and latched. In S_SRCH, every cell compares its entry with the
// search key (key, or value for delete by value) and the match bits are registered. In
// S_UPD, the command is decoded, the chain shifts up or down by one place for an insert
// or delete, and the result register is loaded. A new command word is taken only in
// S_IDLE, so no command is accepted while the previous one is still in progress. The
// update step waits while the output register still holds an untaken result word.
// Every command gives exactly one result word with status and list length.
module ordered_list_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  olist_pkg::t_in_word  i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output olist_pkg::t_out_word o_word
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SRCH = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    olist_pkg::t_in_word         r_cmd;
    logic [olist_pkg::CNT_W-1:0] r_count;
    logic [olist_pkg::DEPTH-1:0] r_match;
    logic                        r_out_valid;
    olist_pkg::t_out_word        r_out;

    logic                        in_fire;
    logic                        upd_go;
    olist_pkg::t_value           search_key;
    olist_pkg::t_value           cell_entry [olist_pkg::DEPTH];
    logic [olist_pkg::DEPTH-1:0] cell_match;
    olist_pkg::t_cell_ctrl       dec_ctrl;
    olist_pkg::t_cell_ctrl       cell_ctrl;
    olist_pkg::t_out_word        dec_result;

    assign o_ready = (r_state == S_IDLE);
    assign in_fire = i_valid && o_ready;
    // result register frees up when empty or being taken this cycle
    assign upd_go  = (r_state == S_UPD) && (!r_out_valid || i_ready);

    assign search_key = (olist_pkg::t_cmd'(r_cmd.cmd) == olist_pkg::CMD_DEL_VALUE) ?
                        r_cmd.value : r_cmd.key;

    always_comb begin
        cell_ctrl = dec_ctrl;
        if (!upd_go) begin
            cell_ctrl.op = olist_pkg::CELL_HOLD;
        end
    end

    for (genvar g = 0; g < olist_pkg::DEPTH; g++) begin : g_cell
        olist_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (olist_pkg::IDX_W'(g)),
            .i_ctrl  (cell_ctrl),
            .i_key   (search_key),
            .i_left  (cell_entry[(g == 0) ? 0 : g - 1]),
            .i_right (cell_entry[(g == olist_pkg::DEPTH - 1) ? g : g + 1]),
            .o_entry (cell_entry[g]),
            .o_match (cell_match[g])
        );
    end

    olist_ctrl u_ctrl (
        .i_cmd_word  (r_cmd),
        .i_count     (r_count),
        .i_match     (r_match),
        .i_entries   (cell_entry),
        .o_cell_ctrl (dec_ctrl),
        .o_result    (dec_result)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (upd_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (upd_go) begin
                r_count     <= dec_result.list_length;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_word;
        end
        if (r_state == S_SRCH) begin
            // only cells holding live entries may match
            for (int i = 0; i < olist_pkg::DEPTH; i++) begin
                r_match[i] <= cell_match[i] && (olist_pkg::CNT_W'(i) < r_count);
            end
        end
        if (upd_go) begin
            r_out <= dec_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= olist_pkg::CNT_W'(olist_pkg::DEPTH))
        else $error("entry count above depth");

    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go |=> (r_count == $past(r_count)) ||
                   (r_count == $past(r_count) + olist_pkg::CNT_W'(1)) ||
                   (r_count == $past(r_count) - olist_pkg::CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_not_found_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_word.status == olist_pkg::ST_NOT_FOUND) |->
            (o_word.found_position == '0))
        else $error("not found result carries a position");

    a_chain_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !upd_go |=> (r_count == $past(r_count)))
        else $error("count changed outside the update step");

    a_result_on_update : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go |=> o_valid && (o_word.list_length == r_count))
        else $error("result word does not report the new length");

endmodule
